// ===== rtl/dfel_pkg.sv =====
// ----------------------------------------------------------------------------
// dfel_pkg
// Shared types and constants of the fault event ring log.
// ----------------------------------------------------------------------------
package dfel_pkg;

  localparam int LOG_ENTRIES  = 20;
  localparam int ACTIVE_SLOTS = 32;
  localparam int LW = (LOG_ENTRIES > 1) ? $clog2(LOG_ENTRIES) : 1;
  localparam int AW = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;

  localparam logic [1:0] REQ_EVENT = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [15:0] SEQ_EMPTY   = 16'hFFFF;
  localparam logic [15:0] LIMIT_RESET = 16'h0FFF;
  localparam logic [31:0] TIME_MOD    = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] code;
    logic [31:0] tstamp;
    logic [15:0] pump;
    logic [15:0] fan;
    logic [15:0] temp;
    logic [15:0] press;
    logic [15:0] flow;
    logic [15:0] volt;
  } entry_t;

endpackage

// ===== rtl/dfel_if.sv =====
// ----------------------------------------------------------------------------
// dfel_req_if / dfel_rsp_if
// Request and result channels of the fault event ring log.
// ----------------------------------------------------------------------------
interface dfel_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  sensor_id;
  logic        is_normal;
  logic [15:0] event_code;
  logic [31:0] uptime_seconds;
  logic [15:0] pump_duty_in;
  logic [15:0] fan_duty_in;
  logic [15:0] outlet_temp_in;
  logic [15:0] outlet_press_in;
  logic [15:0] flow_rate_in;
  logic [15:0] volt_in;
  logic [7:0]  read_order;

  modport source (output valid, req_type, sensor_id, is_normal, event_code, uptime_seconds,
                  pump_duty_in, fan_duty_in, outlet_temp_in, outlet_press_in, flow_rate_in,
                  volt_in, read_order, input ready);
  modport sink (input valid, req_type, sensor_id, is_normal, event_code, uptime_seconds,
                pump_duty_in, fan_duty_in, outlet_temp_in, outlet_press_in, flow_rate_in,
                volt_in, read_order, output ready);
endinterface

interface dfel_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_out;
  logic [15:0] code_out;
  logic [31:0] time_out;
  logic [15:0] pump_out;
  logic [15:0] fan_out;
  logic [15:0] temp_out;
  logic [15:0] press_out;
  logic [15:0] flow_out;
  logic [15:0] volt_out;
  logic [4:0]  written_slot;
  logic        was_logged;
  logic [4:0]  entry_count;

  modport source (output valid, seq_out, code_out, time_out, pump_out, fan_out, temp_out,
                  press_out, flow_out, volt_out, written_slot, was_logged, entry_count,
                  input ready);
  modport sink (input valid, seq_out, code_out, time_out, pump_out, fan_out, temp_out,
                press_out, flow_out, volt_out, written_slot, was_logged, entry_count,
                output ready);
endinterface

// ===== rtl/dfel_store.sv =====
// ----------------------------------------------------------------------------
// dfel_store
// Active sensor store with one indexed port and a match/free compare.
// ----------------------------------------------------------------------------
module dfel_store import dfel_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic [AW-1:0] idx,
  input  logic [7:0]    key,
  input  logic          we,
  input  logic [7:0]    wdata,
  output logic          hit,
  output logic          free
);

  logic [7:0] slots [ACTIVE_SLOTS];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < ACTIVE_SLOTS; i++) slots[i] <= '0;
    end else if (we) begin
      slots[idx] <= wdata;
    end
  end

  assign hit  = (slots[idx] == key);
  assign free = (slots[idx] == 8'd0);

endmodule

// ===== rtl/dfel_log.sv =====
// ----------------------------------------------------------------------------
// dfel_log
// Ring log entries, one read and one write address, cleared to all ones.
// ----------------------------------------------------------------------------
module dfel_log import dfel_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic [LW-1:0] raddr,
  output entry_t        rdata,
  input  logic          we,
  input  logic [LW-1:0] waddr,
  input  entry_t        wdata
);

  entry_t ents [LOG_ENTRIES];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < LOG_ENTRIES; i++) ents[i] <= '1;
    end else if (we) begin
      ents[waddr] <= wdata;
    end
  end

  assign rdata = ents[raddr];

endmodule

// ===== rtl/dedup_fault_event_ring_log_unit.sv =====
// ----------------------------------------------------------------------------
// dedup_fault_event_ring_log_unit
// Fault event recorder: active sensor store plus sequence-numbered ring log.
// ----------------------------------------------------------------------------
// One item at a time; ready is high only while idle. A sensor event walks the
// store one slot a cycle; an abnormal sensor already stored, or a normal one
// not stored, then goes straight to counting. Otherwise it walks the log one
// entry a cycle to find the newest entry, writes, reads back, and walks the
// log again to count entries. A read scans the log, reads the entry and
// counts; a clear goes straight to counting. The result sits in an output
// register until taken.
module dedup_fault_event_ring_log_unit import dfel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  dfel_req_if.sink    req_ch,
  dfel_rsp_if.source  rsp_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_STORE = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_COUNT = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0]    state;
  logic [15:0]   limit;
  logic [1:0]    rtype;
  logic [7:0]    sensor;
  logic          normal;
  logic [15:0]   code;
  logic [31:0]   tmod;
  logic [15:0]   pump, fan, temp, press, flow, volt;
  logic [7:0]    order;
  logic [AW-1:0] sidx;
  logic [LW-1:0] lidx;
  logic [15:0]   prev;
  logic [LW-1:0] brk;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          log_it;
  logic [15:0]   use_code;
  logic [LW-1:0] rd_slot;
  entry_t        res;
  logic [4:0]    res_slot;
  logic          res_logged;
  logic [4:0]    res_count;
  logic          out_valid;

  logic          st_clear, st_we, st_hit, st_free;
  logic [AW-1:0] st_idx;
  logic [7:0]    st_wdata;
  logic          lg_clear, lg_we;
  logic [LW-1:0] lg_raddr, lg_waddr;
  entry_t        lg_rdata, lg_wdata;

  logic          accept;
  logic          s_last, l_last, cont;
  logic [8:0]    v;
  logic [LW-1:0] slot_calc, dst;
  logic [15:0]   nseq;
  logic [31:0]   up;

  assign accept = req_ch.valid && req_ch.ready;
  assign req_ch.ready = (state == S_IDLE);
  assign s_last = (sidx == AW'(ACTIVE_SLOTS - 1));
  assign l_last = (lidx == LW'(LOG_ENTRIES - 1));
  assign cont = (lg_rdata.seq == prev + 16'd1 && prev != 16'hFFFF) ||
                (lg_rdata.seq == 16'd1 && prev == limit);
  assign up = req_ch.uptime_seconds;

  always_comb begin
    v = 9'(brk) + 9'(LOG_ENTRIES + 1) - {1'b0, order};
    if (v >= 9'(2 * LOG_ENTRIES)) v = v - 9'(2 * LOG_ENTRIES);
    else if (v >= 9'(LOG_ENTRIES)) v = v - 9'(LOG_ENTRIES);
    slot_calc = (order > 8'(LOG_ENTRIES)) ? '0 : v[LW-1:0];
  end

  always_comb begin
    if (lg_rdata.seq == SEQ_EMPTY) dst = rd_slot;
    else if (rd_slot == LW'(LOG_ENTRIES - 1)) dst = '0;
    else dst = rd_slot + LW'(1);
    nseq = (lg_rdata.seq == limit || lg_rdata.seq == SEQ_EMPTY) ? 16'd1
         : lg_rdata.seq + 16'd1;
  end

  assign st_clear = accept && req_ch.req_type == REQ_CLEAR;
  assign lg_clear = st_clear;
  assign st_idx   = (state == S_STORE) ? sidx : free_idx;
  // new abnormal sensor goes into the first free slot once the walk is done
  assign st_we    = (state == S_STORE && normal && st_hit) ||
                    (state == S_SCAN && rtype == REQ_EVENT && !normal && free_found &&
                     lidx == '0);
  assign st_wdata = normal ? 8'd0 : sensor;
  assign lg_raddr = (state == S_SCAN || state == S_COUNT) ? lidx : rd_slot;
  assign lg_we    = (state == S_WRITE);
  assign lg_waddr = dst;
  assign lg_wdata = '{seq: nseq, code: use_code, tstamp: {tmod[15:0], tmod[31:16]},
                      pump: pump, fan: fan, temp: temp, press: press, flow: flow,
                      volt: volt};

  dfel_store u_store (
    .clk(clk), .rst(rst), .clear(st_clear), .idx(st_idx), .key(sensor),
    .we(st_we), .wdata(st_wdata), .hit(st_hit), .free(st_free)
  );

  dfel_log u_log (
    .clk(clk), .rst(rst), .clear(lg_clear), .raddr(lg_raddr), .rdata(lg_rdata),
    .we(lg_we), .waddr(lg_waddr), .wdata(lg_wdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      limit     <= LIMIT_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) limit <= cfg_wdata;
      if (state == S_DONE && (!out_valid || rsp_ch.ready)) out_valid <= 1'b1;
      else if (out_valid && rsp_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rtype  <= req_ch.req_type;
            sensor <= req_ch.sensor_id;
            normal <= req_ch.is_normal;
            code   <= req_ch.event_code;
            if (up >= 32'hFFFF_FFFE) tmod <= up - 32'hFFFF_FFFE;
            else if (up >= TIME_MOD) tmod <= up - TIME_MOD;
            else tmod <= up;
            pump  <= req_ch.pump_duty_in;
            fan   <= req_ch.fan_duty_in;
            temp  <= req_ch.outlet_temp_in;
            press <= req_ch.outlet_press_in;
            flow  <= req_ch.flow_rate_in;
            volt  <= req_ch.volt_in;
            order <= (req_ch.req_type == REQ_READ) ? req_ch.read_order : 8'd1;
            sidx  <= '0;
            lidx  <= '0;
            free_found <= 1'b0;
            free_idx   <= '0;
            log_it     <= 1'b0;
            use_code   <= 16'd0;
            res        <= '0;
            res_slot   <= '0;
            res_logged <= 1'b0;
            unique case (req_ch.req_type)
              REQ_EVENT: state <= S_STORE;
              REQ_READ:  state <= S_SCAN;
              default:   state <= S_COUNT;
            endcase
          end
        end
        S_STORE: begin
          sidx <= sidx + AW'(1);
          if (normal) begin
            if (st_hit) begin
              use_code <= code;
              state <= S_SCAN;
            end else if (s_last) begin
              state <= S_COUNT;
            end
          end else if (st_hit) begin
            state <= S_COUNT;
          end else begin
            if (st_free && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= sidx;
            end
            if (s_last) begin
              use_code <= (free_found || st_free) ? code : 16'd0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          prev <= lg_rdata.seq;
          lidx <= lidx + LW'(1);
          if (lidx != '0 && !cont) begin
            brk   <= lidx - LW'(1);
            state <= S_CALC;
          end else if (l_last) begin
            brk   <= lidx;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          rd_slot <= slot_calc;
          state   <= (rtype == REQ_EVENT) ? S_WRITE : S_READ;
        end
        S_WRITE: begin
          log_it  <= 1'b1;
          rd_slot <= dst;
          state   <= S_READ;
        end
        S_READ: begin
          res        <= lg_rdata;
          res_slot   <= 5'(rd_slot);
          res_logged <= log_it;
          lidx       <= '0;
          state      <= S_COUNT;
        end
        S_COUNT: begin
          lidx <= lidx + LW'(1);
          if (lg_rdata.seq == SEQ_EMPTY) begin
            res_count <= 5'(lidx);
            state <= S_DONE;
          end else if (l_last) begin
            res_count <= 5'(LOG_ENTRIES);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || rsp_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!out_valid || rsp_ch.ready)) begin
      rsp_ch.seq_out      <= res.seq;
      rsp_ch.code_out     <= res.code;
      rsp_ch.time_out     <= res.tstamp;
      rsp_ch.pump_out     <= res.pump;
      rsp_ch.fan_out      <= res.fan;
      rsp_ch.temp_out     <= res.temp;
      rsp_ch.press_out    <= res.press;
      rsp_ch.flow_out     <= res.flow;
      rsp_ch.volt_out     <= res.volt;
      rsp_ch.written_slot <= res_slot;
      rsp_ch.was_logged   <= res_logged;
      rsp_ch.entry_count  <= res_count;
    end
  end

  assign rsp_ch.valid = out_valid;

endmodule

// ===== rtl/dfel_checker.sv =====
// ----------------------------------------------------------------------------
// dfel_checker
// Port-level checks of the fault event ring log, bound to the top level.
// ----------------------------------------------------------------------------
module dfel_checker import dfel_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [4:0] written_slot,
  input logic       was_logged,
  input logic [4:0] entry_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while busy");

  a_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> entry_count <= 5'(LOG_ENTRIES))
    else $error("entry count out of range");

  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && was_logged |-> written_slot < 5'(LOG_ENTRIES) && entry_count != 5'd0)
    else $error("logged item without entry");

endmodule

bind dedup_fault_event_ring_log_unit dfel_checker u_dfel_checker (
  .clk(clk), .rst(rst),
  .in_valid(req_ch.valid), .in_ready(req_ch.ready),
  .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready),
  .written_slot(rsp_ch.written_slot), .was_logged(rsp_ch.was_logged),
  .entry_count(rsp_ch.entry_count)
);
